/* rtl/gpip_pkg.sv */
package gpip_pkg;

   localparam int MAX_VERTICES     = 256;
   localparam int COORD_BITS       = 24;
   localparam int INDEX_BITS       = 10;
   localparam int SLOT_BITS        = 8;
   localparam int COUNT_FIELD_BITS = 9;
   localparam int CELL_BITS        = 16;

   localparam int ADDR_BITS  = $clog2(MAX_VERTICES);
   localparam int CNT_BITS   = $clog2(MAX_VERTICES + 1);
   localparam int DC_BITS    = COORD_BITS + 1;
   localparam int CTR_BITS   = INDEX_BITS + 1 + CELL_BITS;
   localparam int WIDE_BITS  = (CTR_BITS > DC_BITS) ? CTR_BITS : DC_BITS;
   localparam int LPROD_BITS = WIDE_BITS + DC_BITS;
   localparam int RPROD_BITS = 2 * DC_BITS;
   localparam int CMP_BITS   = ((LPROD_BITS > RPROD_BITS) ? LPROD_BITS : RPROD_BITS) + 1;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam int PADDR_BITS = 4;
   localparam int PDATA_BITS = 32;

   localparam logic [COUNT_FIELD_BITS-1:0] VERTEX_COUNT_RESET = 9'd2;
   localparam logic [CELL_BITS-1:0]        CELL_WIDTH_RESET   = 16'd256;
   localparam logic [CELL_BITS-1:0]        CELL_HEIGHT_RESET  = 16'd256;

   typedef enum logic {
      FUNC_LOAD  = 1'b0,
      FUNC_QUERY = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      REG_VERTEX_COUNT = 2'd0,
      REG_CELL_WIDTH   = 2'd1,
      REG_CELL_HEIGHT  = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [COUNT_FIELD_BITS-1:0] vertex_count;
      logic [CELL_BITS-1:0]        cell_width;
      logic [CELL_BITS-1:0]        cell_height;
   } cfg_type;

   typedef struct packed {
      func_type               func;
      logic [SLOT_BITS-1:0]   slot;
      logic [COORD_BITS-1:0]  x;
      logic [COORD_BITS-1:0]  y;
      logic [CTR_BITS-1:0]    xc;
      logic [CTR_BITS-1:0]    yc;
      logic [INDEX_BITS-1:0]  col;
      logic [INDEX_BITS-1:0]  row;
   } item_type;

endpackage

/* rtl/gpip_req_if.sv */
interface gpip_req_if import gpip_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  func;
   logic [SLOT_BITS-1:0]  vertex_index;
   logic [COORD_BITS-1:0] vertex_x;
   logic [COORD_BITS-1:0] vertex_y;
   logic [INDEX_BITS-1:0] cell_column;
   logic [INDEX_BITS-1:0] cell_row;

   modport source (
      output valid, func, vertex_index, vertex_x, vertex_y, cell_column, cell_row,
      input  ready
   );

   modport sink (
      input  valid, func, vertex_index, vertex_x, vertex_y, cell_column, cell_row,
      output ready
   );
endinterface

/* rtl/gpip_rsp_if.sv */
interface gpip_rsp_if import gpip_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  inside_res;
   logic [INDEX_BITS-1:0] result_column;
   logic [INDEX_BITS-1:0] result_row;

   modport source (
      output valid, inside_res, result_column, result_row,
      input  ready
   );

   modport sink (
      input  valid, inside_res, result_column, result_row,
      output ready
   );
endinterface

/* rtl/gpip_csr.sv */
module gpip_csr import gpip_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [PADDR_BITS-1:0] paddr,
   input  logic [PDATA_BITS-1:0] pwdata,
   output logic [PDATA_BITS-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type cfg_ff, cfg_in;
   logic    wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (paddr[PADDR_BITS-1:2])
            REG_VERTEX_COUNT: cfg_in.vertex_count = pwdata[COUNT_FIELD_BITS-1:0];
            REG_CELL_WIDTH:   cfg_in.cell_width   = pwdata[CELL_BITS-1:0];
            REG_CELL_HEIGHT:  cfg_in.cell_height  = pwdata[CELL_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (paddr[PADDR_BITS-1:2])
         REG_VERTEX_COUNT: prdata = PDATA_BITS'(cfg_ff.vertex_count);
         REG_CELL_WIDTH:   prdata = PDATA_BITS'(cfg_ff.cell_width);
         REG_CELL_HEIGHT:  prdata = PDATA_BITS'(cfg_ff.cell_height);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.vertex_count <= VERTEX_COUNT_RESET;
         cfg_ff.cell_width   <= CELL_WIDTH_RESET;
         cfg_ff.cell_height  <= CELL_HEIGHT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* rtl/gpip_front.sv */
module gpip_front import gpip_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   gpip_req_if.sink req_if,
   input  cfg_type  cfg,
   output logic     push_valid,
   output item_type push_item,
   input  logic     push_ready
);

   logic                hold_valid_ff, hold_valid_in;
   item_type            hold_item_ff, hold_item_in;
   logic                take;
   logic [CTR_BITS-1:0] xc_w;
   logic [CTR_BITS-1:0] yc_w;

   assign req_if.ready = !hold_valid_ff || push_ready;
   assign take         = req_if.valid && req_if.ready;
   assign push_valid   = hold_valid_ff;
   assign push_item    = hold_item_ff;

   // cell centre with 1 fraction bit (doubled scale): (2*index + 1) * size
   assign xc_w = CTR_BITS'({req_if.cell_column, 1'b1}) * CTR_BITS'(cfg.cell_width);
   assign yc_w = CTR_BITS'({req_if.cell_row, 1'b1}) * CTR_BITS'(cfg.cell_height);

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_item_in  = hold_item_ff;
      if (push_ready) begin
         hold_valid_in = 1'b0;
      end
      if (take) begin
         hold_valid_in     = 1'b1;
         hold_item_in.func = func_type'(req_if.func);
         hold_item_in.slot = req_if.vertex_index;
         hold_item_in.x    = req_if.vertex_x;
         hold_item_in.y    = req_if.vertex_y;
         hold_item_in.xc   = xc_w;
         hold_item_in.yc   = yc_w;
         hold_item_in.col  = req_if.cell_column;
         hold_item_in.row  = req_if.cell_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_item_ff <= hold_item_in;
   end

endmodule

/* rtl/gpip_queue.sv */
module gpip_queue import gpip_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   input  item_type push_item,
   output logic     push_ready,
   output logic     pop_valid,
   output item_type pop_item,
   input  logic     pop_ready
);

   item_type               entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wptr_ff, wptr_in;
   logic [QPTR_BITS-1:0]   rptr_ff, rptr_in;
   logic [QCNT_BITS-1:0]   count_ff, count_in;
   logic                   push;
   logic                   pop;

   assign push_ready = count_ff != QCNT_BITS'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_item   = entry_ff[rptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff + QCNT_BITS'(push) - QCNT_BITS'(pop);
      if (push) begin
         wptr_in = (wptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (pop) begin
         rptr_in = (rptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wptr_ff] <= push_item;
      end
   end

endmodule

/* rtl/gpip_walk.sv */
module gpip_walk import gpip_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       pop_valid,
   input  item_type   pop_item,
   output logic       pop_ready,
   gpip_rsp_if.source rsp_if
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_WALK = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic [COORD_BITS-1:0] x_store_ff [MAX_VERTICES];
   logic [COORD_BITS-1:0] y_store_ff [MAX_VERTICES];

   logic [WIDE_BITS-1:0]  xc_ff, xc_in, yc_ff, yc_in;
   logic [INDEX_BITS-1:0] col_ff, col_in, row_ff, row_in;
   logic [CNT_BITS-1:0]   n_ff, n_in, rd_cnt_ff, rd_cnt_in;
   logic                  parity_ff, parity_in;

   logic                  pop;
   logic                  wr_en;
   logic                  start_walk;
   logic                  rd_en;
   logic                  walk_done;
   logic                  rsp_free;
   logic [ADDR_BITS-1:0]  wr_addr;
   logic [ADDR_BITS-1:0]  rd_addr;

   // read stage
   logic                  rv_ff;
   logic [COORD_BITS-1:0] rd_x_ff, rd_y_ff;

   // ring tracking and edge stage
   logic                  have_prev_ff, have_prev_in;
   logic [COORD_BITS-1:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic [COORD_BITS-1:0] start_x_ff, start_x_in, start_y_ff, start_y_in;
   logic                  same_start;
   logic                  ev_ff, ev_in;
   logic [COORD_BITS-1:0] e_x0_ff, e_x0_in, e_y0_ff, e_y0_in;
   logic [COORD_BITS-1:0] e_x1_ff, e_x1_in, e_y1_ff, e_y1_in;

   // straddle stage
   logic [WIDE_BITS-1:0]  x0d, y0d, x1d, y1d;
   logic                  up, down;
   logic                  cv_ff, cv_in;
   logic [WIDE_BITS-1:0]  c_mx_ff, c_mx_in;
   logic [DC_BITS-1:0]    c_dyp_ff, c_dyp_in, c_b_ff, c_b_in, c_mdx_ff, c_mdx_in;
   logic                  c_lneg_ff, c_lneg_in, c_rneg_ff, c_rneg_in;

   // product stage
   logic                  mv_ff, mv_in;
   logic [LPROD_BITS-1:0] m_lp_ff, m_lp_in;
   logic [RPROD_BITS-1:0] m_rp_ff, m_rp_in;
   logic                  m_lneg_ff, m_rneg_ff;

   // compare stage
   logic signed [CMP_BITS-1:0] l_val, r_val;
   logic                       crossing;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_inside_ff;
   logic [INDEX_BITS-1:0] rsp_col_ff, rsp_row_ff;

   assign pop_ready  = state_ff == ST_IDLE;
   assign pop        = pop_valid && pop_ready;
   assign wr_en      = pop && (pop_item.func == FUNC_LOAD) &&
                       (32'(pop_item.slot) < MAX_VERTICES);
   assign start_walk = pop && (pop_item.func == FUNC_QUERY);
   assign wr_addr    = ADDR_BITS'(pop_item.slot);
   assign rd_en      = (state_ff == ST_WALK) && (rd_cnt_ff != n_ff);
   assign rd_addr    = rd_cnt_ff[ADDR_BITS-1:0];
   assign walk_done  = (state_ff == ST_WALK) && (rd_cnt_ff == n_ff) &&
                       !rv_ff && !ev_ff && !cv_ff && !mv_ff;
   assign rsp_free   = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      state_in  = state_ff;
      xc_in     = xc_ff;
      yc_in     = yc_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      n_in      = n_ff;
      rd_cnt_in = rd_cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start_walk) begin
               state_in  = ST_WALK;
               xc_in     = WIDE_BITS'(pop_item.xc);
               yc_in     = WIDE_BITS'(pop_item.yc);
               col_in    = pop_item.col;
               row_in    = pop_item.row;
               rd_cnt_in = '0;
               n_in      = (32'(cfg.vertex_count) > MAX_VERTICES) ?
                           CNT_BITS'(MAX_VERTICES) : CNT_BITS'(cfg.vertex_count);
            end
         end
         ST_WALK: begin
            if (rd_en) begin
               rd_cnt_in = rd_cnt_ff + 1'b1;
            end
            if (walk_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ring tracking: a vertex equal to its ring's first one closes the ring
   assign same_start = (rd_x_ff == start_x_ff) && (rd_y_ff == start_y_ff);

   always_comb begin
      have_prev_in = have_prev_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      start_x_in   = start_x_ff;
      start_y_in   = start_y_ff;
      ev_in        = rv_ff && have_prev_ff;
      e_x0_in      = prev_x_ff;
      e_y0_in      = prev_y_ff;
      e_x1_in      = rd_x_ff;
      e_y1_in      = rd_y_ff;
      if (start_walk) begin
         have_prev_in = 1'b0;
      end else if (rv_ff) begin
         if (have_prev_ff) begin
            have_prev_in = !same_start;
            prev_x_in    = rd_x_ff;
            prev_y_in    = rd_y_ff;
         end else begin
            have_prev_in = 1'b1;
            prev_x_in    = rd_x_ff;
            prev_y_in    = rd_y_ff;
            start_x_in   = rd_x_ff;
            start_y_in   = rd_y_ff;
         end
      end
   end

   assign x0d  = WIDE_BITS'({e_x0_ff, 1'b0});
   assign y0d  = WIDE_BITS'({e_y0_ff, 1'b0});
   assign x1d  = WIDE_BITS'({e_x1_ff, 1'b0});
   assign y1d  = WIDE_BITS'({e_y1_ff, 1'b0});
   assign up   = (y0d <= yc_ff) && (y1d > yc_ff);
   assign down = (y0d > yc_ff) && (y1d <= yc_ff);

   always_comb begin
      cv_in     = ev_ff && (up || down);
      c_dyp_in  = up ? DC_BITS'(y1d - y0d) : DC_BITS'(y0d - y1d);
      c_b_in    = up ? DC_BITS'(yc_ff - y0d) : DC_BITS'(y0d - yc_ff);
      c_lneg_in = xc_ff < x0d;
      c_mx_in   = c_lneg_in ? (x0d - xc_ff) : (xc_ff - x0d);
      c_rneg_in = x1d < x0d;
      c_mdx_in  = c_rneg_in ? DC_BITS'(x0d - x1d) : DC_BITS'(x1d - x0d);
   end

   // crossing right of the centre: (xc - x0) * dy < (yc - y0) * (x1 - x0)
   assign mv_in   = cv_ff;
   assign m_lp_in = LPROD_BITS'(c_mx_ff) * LPROD_BITS'(c_dyp_ff);
   assign m_rp_in = RPROD_BITS'(c_b_ff) * RPROD_BITS'(c_mdx_ff);

   always_comb begin
      l_val = $signed(CMP_BITS'(m_lp_ff));
      r_val = $signed(CMP_BITS'(m_rp_ff));
      if (m_lneg_ff) begin
         l_val = -l_val;
      end
      if (m_rneg_ff) begin
         r_val = -r_val;
      end
      crossing = l_val < r_val;
   end

   always_comb begin
      parity_in = parity_ff;
      if (start_walk) begin
         parity_in = 1'b0;
      end else if (mv_ff && crossing) begin
         parity_in = !parity_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if ((state_ff == ST_EMIT) && rsp_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.inside_res    = rsp_inside_ff;
   assign rsp_if.result_column = rsp_col_ff;
   assign rsp_if.result_row    = rsp_row_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_cnt_ff    <= '0;
         n_ff         <= '0;
         parity_ff    <= 1'b0;
         have_prev_ff <= 1'b0;
         rv_ff        <= 1'b0;
         ev_ff        <= 1'b0;
         cv_ff        <= 1'b0;
         mv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_cnt_ff    <= rd_cnt_in;
         n_ff         <= n_in;
         parity_ff    <= parity_in;
         have_prev_ff <= have_prev_in;
         rv_ff        <= rd_en;
         ev_ff        <= ev_in;
         cv_ff        <= cv_in;
         mv_ff        <= mv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      xc_ff      <= xc_in;
      yc_ff      <= yc_in;
      col_ff     <= col_in;
      row_ff     <= row_in;
      prev_x_ff  <= prev_x_in;
      prev_y_ff  <= prev_y_in;
      start_x_ff <= start_x_in;
      start_y_ff <= start_y_in;
      e_x0_ff    <= e_x0_in;
      e_y0_ff    <= e_y0_in;
      e_x1_ff    <= e_x1_in;
      e_y1_ff    <= e_y1_in;
      c_mx_ff    <= c_mx_in;
      c_dyp_ff   <= c_dyp_in;
      c_b_ff     <= c_b_in;
      c_mdx_ff   <= c_mdx_in;
      c_lneg_ff  <= c_lneg_in;
      c_rneg_ff  <= c_rneg_in;
      m_lp_ff    <= m_lp_in;
      m_rp_ff    <= m_rp_in;
      m_lneg_ff  <= c_lneg_ff;
      m_rneg_ff  <= c_rneg_ff;
      if ((state_ff == ST_EMIT) && rsp_free) begin
         rsp_inside_ff <= parity_ff;
         rsp_col_ff    <= col_ff;
         rsp_row_ff    <= row_ff;
      end
   end

   // vertex memory: one write port for loads, one registered read port for the walk
   always_ff @(posedge clock) begin
      if (wr_en) begin
         x_store_ff[wr_addr] <= pop_item.x;
         y_store_ff[wr_addr] <= pop_item.y;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_x_ff <= x_store_ff[rd_addr];
         rd_y_ff <= y_store_ff[rd_addr];
      end
   end

endmodule

/* rtl/grid_point_in_polygon_test.sv */
// Point-in-polygon test over a grid of cells. Load items (func 0) write one vertex into
// the vertex memory; rings follow one another and a ring ends at the vertex that repeats
// its first one. Query items (func 1) form the centre of cell (column, row) from the
// cell_width and cell_height registers and return inside_res by the crossing-number rule,
// with the column and row echoed. Loads give no result. Items are handled strictly in
// order: the front end computes the cell centre and queues the item, the back end writes
// loads into the vertex memory and walks the polygon for queries, reading one vertex per
// cycle from the single read port of the vertex memory. A query walks vertex_count
// vertices, capped at the memory depth; a result waiting in the output register does
// not stop the next items from entering. Registers are written only while the block is
// idle: the user must keep to this, the block itself does not enforce it. Every vertex
// a query walks over must have been loaded before.
module grid_point_in_polygon_test import gpip_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   gpip_req_if.sink              req_if,
   gpip_rsp_if.source            rsp_if,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [PADDR_BITS-1:0] paddr,
   input  logic [PDATA_BITS-1:0] pwdata,
   output logic [PDATA_BITS-1:0] prdata,
   output logic                  pready
);

   cfg_type  cfg;
   logic     push_valid;
   item_type push_item;
   logic     push_ready;
   logic     pop_valid;
   item_type pop_item;
   logic     pop_ready;

   gpip_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   gpip_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .cfg        (cfg),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready)
   );

   gpip_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop_ready  (pop_ready)
   );

   gpip_walk u_walk (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .pop_valid (pop_valid),
      .pop_item  (pop_item),
      .pop_ready (pop_ready),
      .rsp_if    (rsp_if)
   );

endmodule

/* tb/sv/grid_point_in_polygon_test_tb.sv */
`timescale 1ns / 1ps

module grid_point_in_polygon_test_tb;
   import gpip_pkg::*;

   localparam int ITEM_TARGET    = 1400;
   localparam int SETTLE_CYCLES  = 300;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int unsigned UNIT  = 256;
   localparam logic [COORD_BITS-1:0] COORD_MAX = '1;

   typedef struct {
      func_type              func;
      logic [SLOT_BITS-1:0]  slot;
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [INDEX_BITS-1:0] col;
      logic [INDEX_BITS-1:0] row;
   } poly_req_type;

   typedef struct {
      logic                  hit;
      logic [INDEX_BITS-1:0] col;
      logic [INDEX_BITS-1:0] row;
   } cell_verdict_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [PADDR_BITS-1:0] paddr;
   logic [PDATA_BITS-1:0] pwdata;
   logic [PDATA_BITS-1:0] prdata;
   logic                  pready;

   gpip_req_if req_if ();
   gpip_rsp_if rsp_if ();

   grid_point_in_polygon_test u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .rsp_if  (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // shadow of the block's registers and vertex memory
   logic [COUNT_FIELD_BITS-1:0] model_vertex_count = VERTEX_COUNT_RESET;
   logic [CELL_BITS-1:0]        model_cell_width   = CELL_WIDTH_RESET;
   logic [CELL_BITS-1:0]        model_cell_height  = CELL_HEIGHT_RESET;
   logic [COORD_BITS-1:0]       model_x [MAX_VERTICES];
   logic [COORD_BITS-1:0]       model_y [MAX_VERTICES];

   cell_verdict_type expected_cells [$];
   int            mismatch_count = 0;
   int            items_accepted = 0;
   int unsigned   burst_left     = 0;
   int unsigned   idle_cycles    = 0;
   int unsigned   rsp_mode       = 0;
   int unsigned   rsp_mode_left  = 0;
   int unsigned   rsp_phase      = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // crossing-number test at the cell centre, all in doubled (1 fraction bit) scale
   function automatic logic cell_centre_inside(input logic [INDEX_BITS-1:0] col,
                                               input logic [INDEX_BITS-1:0] row);
      longint xc, yc, x0, y0, x1, y1, dyp, b;
      int     n, v, start;
      logic   odd;
      bit     rising, falling;
      xc = (2 * longint'(col) + 1) * longint'(model_cell_width);
      yc = (2 * longint'(row) + 1) * longint'(model_cell_height);
      n = (model_vertex_count > MAX_VERTICES) ? MAX_VERTICES : int'(model_vertex_count);
      v = 0;
      start = 0;
      odd = 1'b0;
      while (n >= 2 && v + 1 < n) begin
         x0 = 2 * longint'(model_x[v]);
         y0 = 2 * longint'(model_y[v]);
         x1 = 2 * longint'(model_x[v+1]);
         y1 = 2 * longint'(model_y[v+1]);
         rising  = (y0 <= yc) && (y1 > yc);
         falling = (y0 > yc) && (y1 <= yc);
         if (rising || falling) begin
            dyp = rising ? y1 - y0 : y0 - y1;
            b   = rising ? yc - y0 : y0 - yc;
            if ((xc - x0) * dyp < b * (x1 - x0)) odd = ~odd;
         end
         v++;
         // vertex repeating the ring start closes the ring
         if (model_x[v] == model_x[start] && model_y[v] == model_y[start]) begin
            v++;
            start = v;
         end
      end
      return odd;
   endfunction

   task automatic send_item(input poly_req_type item);
      int unsigned  gap;
      cell_verdict_type verdict;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_if.valid        <= 1'b1;
      req_if.func         <= item.func;
      req_if.vertex_index <= item.slot;
      req_if.vertex_x     <= item.x;
      req_if.vertex_y     <= item.y;
      req_if.cell_column  <= item.col;
      req_if.cell_row     <= item.row;
      do @(posedge clock); while (!req_if.ready);
      items_accepted++;
      if (item.func == FUNC_LOAD) begin
         model_x[item.slot] = item.x;
         model_y[item.slot] = item.y;
      end else begin
         verdict.hit = cell_centre_inside(item.col, item.row);
         verdict.col = item.col;
         verdict.row = item.row;
         expected_cells.push_back(verdict);
      end
   endtask

   task automatic load_vertex(input int unsigned slot, input int unsigned x,
                              input int unsigned y);
      poly_req_type item;
      item.func = FUNC_LOAD;
      item.slot = slot[SLOT_BITS-1:0];
      item.x    = x[COORD_BITS-1:0];
      item.y    = y[COORD_BITS-1:0];
      item.col  = INDEX_BITS'($urandom_range(0, 1023));
      item.row  = INDEX_BITS'($urandom_range(0, 1023));
      send_item(item);
   endtask

   task automatic query_cell(input int unsigned col, input int unsigned row);
      poly_req_type item;
      item.func = FUNC_QUERY;
      item.slot = SLOT_BITS'($urandom_range(0, MAX_VERTICES - 1));
      item.x    = COORD_BITS'($urandom_range(0, COORD_MAX));
      item.y    = COORD_BITS'($urandom_range(0, COORD_MAX));
      item.col  = col[INDEX_BITS-1:0];
      item.row  = row[INDEX_BITS-1:0];
      send_item(item);
   endtask

   task automatic write_reg(input reg_index_type idx, input int unsigned value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= PADDR_BITS'(4 * int'(idx));
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_VERTEX_COUNT: model_vertex_count = value[COUNT_FIELD_BITS-1:0];
         REG_CELL_WIDTH:   model_cell_width   = value[CELL_BITS-1:0];
         REG_CELL_HEIGHT:  model_cell_height  = value[CELL_BITS-1:0];
         default: ;
      endcase
   endtask

   // loads give no result, so let the walker finish after the last query returns
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      burst_left = 0;
      while (expected_cells.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_grid(input int unsigned count, input int unsigned width,
                           input int unsigned height);
      wait_idle();
      write_reg(REG_VERTEX_COUNT, count);
      write_reg(REG_CELL_WIDTH, width);
      write_reg(REG_CELL_HEIGHT, height);
   endtask

   function automatic logic [COORD_BITS-1:0] pick_coord(input int unsigned span,
                                                        input int unsigned pitch,
                                                        input int unsigned cells);
      longint unsigned v;
      case ($urandom_range(0, 9))
         0, 1:    v = ((2 * longint'($urandom_range(0, cells)) + 1) * pitch) >> 1;
         2:       v = $urandom_range(0, 1) ? span : 0;
         default: v = $urandom_range(0, span);
      endcase
      return (v > COORD_MAX) ? COORD_MAX : v[COORD_BITS-1:0];
   endfunction

   function automatic int unsigned pick_pitch();
      case ($urandom_range(0, 9))
         0:       return 1;
         1:       return 65535;
         2:       return $urandom_range(0, 3);
         3, 4:    return $urandom_range(1, 65535);
         default: return $urandom_range(16, 2048);
      endcase
   endfunction

   // rings of 3..8 random vertices, each closed by a repeat of its first; last may be cut short and stay open
   task automatic load_polygon(input int slots, input int unsigned pitch_x,
                               input int unsigned pitch_y, input int unsigned cols,
                               input int unsigned rows);
      logic [COORD_BITS-1:0] px [MAX_VERTICES];
      logic [COORD_BITS-1:0] py [MAX_VERTICES];
      int unsigned span_x, span_y;
      int          i, first, k, j;
      bit          descending;
      span_x = (pitch_x * cols > COORD_MAX) ? COORD_MAX : pitch_x * cols;
      span_y = (pitch_y * rows > COORD_MAX) ? COORD_MAX : pitch_y * rows;
      if (span_x == 0) span_x = 4096;
      if (span_y == 0) span_y = 4096;
      i = 0;
      while (i < slots) begin
         first = i;
         k = $urandom_range(3, 8);
         for (j = 0; j < k && i < slots; j++) begin
            px[i] = pick_coord(span_x, pitch_x, cols);
            if (j > 0 && $urandom_range(0, 5) == 0) py[i] = py[i-1];
            else py[i] = pick_coord(span_y, pitch_y, rows);
            i++;
         end
         if (i < slots) begin
            px[i] = px[first];
            py[i] = py[first];
            i++;
         end
      end
      descending = $urandom_range(0, 1);
      for (j = 0; j < slots; j++) begin
         k = descending ? slots - 1 - j : j;
         load_vertex(k, px[k], py[k]);
      end
   endtask

   // queries mixed with vertex rewrites and loads outside the walked range
   task automatic query_run(input int nq, input int slots, input int unsigned cols,
                            input int unsigned rows);
      int unsigned s, t;
      for (int q = 0; q < nq; q++) begin
         case ($urandom_range(0, 19))
            0: begin
               s = $urandom_range(0, slots - 1);
               t = $urandom_range(0, slots - 1);
               load_vertex(s, model_x[t], model_y[t]);
            end
            1: begin
               if (slots < MAX_VERTICES)
                  load_vertex($urandom_range(slots, MAX_VERTICES - 1),
                              $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
            end
            2:       query_cell($urandom_range(0, 1023), $urandom_range(0, 1023));
            default: query_cell($urandom_range(0, cols), $urandom_range(0, rows));
         endcase
      end
   endtask

   task automatic test_reset_values();
      load_vertex(0, 0, 0);
      load_vertex(1, 2 * UNIT, 4 * UNIT);
      query_cell(0, 0);
      query_cell(0, 1);
      query_cell(1, 0);
      query_cell(3, 3);
   endtask

   // square with a square hole, plus a triangle whose lowest vertex sits on a centre line
   task automatic test_nested_rings();
      set_grid(14, UNIT, UNIT);
      load_vertex(0, 1 * UNIT, 1 * UNIT);
      load_vertex(1, 5 * UNIT, 1 * UNIT);
      load_vertex(2, 5 * UNIT, 5 * UNIT);
      load_vertex(3, 1 * UNIT, 5 * UNIT);
      load_vertex(4, 1 * UNIT, 1 * UNIT);
      load_vertex(5, 2 * UNIT, 2 * UNIT);
      load_vertex(6, 4 * UNIT, 2 * UNIT);
      load_vertex(7, 4 * UNIT, 4 * UNIT);
      load_vertex(8, 2 * UNIT, 4 * UNIT);
      load_vertex(9, 2 * UNIT, 2 * UNIT);
      load_vertex(10, 6 * UNIT, UNIT / 2);
      load_vertex(11, 9 * UNIT, 7 * UNIT / 2);
      load_vertex(12, 6 * UNIT, 13 * UNIT / 2);
      load_vertex(13, 6 * UNIT, UNIT / 2);
      query_cell(0, 0);
      query_cell(1, 1);
      query_cell(3, 3);
      query_cell(4, 1);
      query_cell(6, 3);
      query_cell(7, 0);
      query_cell(6, 1);
      query_cell(1023, 1023);
   endtask

   task automatic test_coordinate_extremes();
      set_grid(4, 65535, 65535);
      load_vertex(0, 0, 0);
      load_vertex(1, COORD_MAX, 0);
      load_vertex(2, COORD_MAX, COORD_MAX);
      load_vertex(3, 0, 0);
      query_cell(0, 0);
      query_cell(255, 0);
      query_cell(0, 255);
      query_cell(100, 60);
      query_cell(255, 255);
      query_cell(1023, 1023);
      set_grid(4, 1, 1);
      query_cell(0, 0);
      query_cell(1023, 1023);
      query_cell(512, 3);
      set_grid(4, 0, 0);
      query_cell(7, 9);
      set_grid(4, 65535, 1);
      query_cell(3, 1023);
   endtask

   task automatic test_vertex_count_limits();
      set_grid(0, UNIT, UNIT);
      query_cell(1, 1);
      query_cell(1023, 0);
      set_grid(1, UNIT, UNIT);
      query_cell(2, 3);
      set_grid(MAX_VERTICES, 4096, 4096);
      load_polygon(MAX_VERTICES, 4096, 4096, 32, 32);
      query_run(4, MAX_VERTICES, 32, 32);
      set_grid(511, 4096, 4096);
      query_run(4, MAX_VERTICES, 32, 32);
   endtask

   task automatic test_random_polygons();
      int unsigned special_counts [6] = '{0, 1, 2, 256, 300, 511};
      int unsigned count, pitch_x, pitch_y, cols, rows;
      int          slots;
      while (items_accepted < ITEM_TARGET) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: count = $urandom_range(3, 30);
            7, 8:                count = $urandom_range(31, 100);
            default:             count = special_counts[$urandom_range(0, 5)];
         endcase
         slots = (count > MAX_VERTICES) ? MAX_VERTICES : ((count < 2) ? 2 : count);
         pitch_x = pick_pitch();
         pitch_y = pick_pitch();
         cols = $urandom_range(2, 40);
         rows = $urandom_range(2, 40);
         set_grid(count, pitch_x, pitch_y);
         load_polygon(slots, pitch_x, pitch_y, cols, rows);
         query_run((slots > 100) ? $urandom_range(3, 6) : $urandom_range(10, 40),
                   slots, cols, rows);
      end
   endtask

   task automatic report_error(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("mismatch: %s", msg);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_mode_left == 0) begin
            rsp_mode      = $urandom_range(0, 3);
            rsp_mode_left = $urandom_range(20, 200);
         end
         rsp_mode_left--;
         rsp_phase++;
         case (rsp_mode)
            0:       rsp_if.ready <= 1'b1;
            1:       rsp_if.ready <= 1'($urandom_range(0, 1));
            2:       rsp_if.ready <= (rsp_phase % 4 == 0);
            default: rsp_if.ready <= (rsp_phase % 24 >= 18);
         endcase
      end
   end

   always @(posedge clock) begin
      cell_verdict_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_cells.size() == 0) begin
            report_error($sformatf("result inside %0b col %0d row %0d with no query pending",
                                   rsp_if.inside_res, rsp_if.result_column,
                                   rsp_if.result_row));
         end else begin
            want = expected_cells.pop_front();
            if (rsp_if.inside_res !== want.hit || rsp_if.result_column !== want.col ||
                rsp_if.result_row !== want.row)
               report_error($sformatf(
                  "expected inside %0b col %0d row %0d, got inside %0b col %0d row %0d",
                  want.hit, want.col, want.row,
                  rsp_if.inside_res, rsp_if.result_column, rsp_if.result_row));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (psel && penable && pwrite && pready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[grid_point_in_polygon_test] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset               = 1'b1;
      psel                = 1'b0;
      penable             = 1'b0;
      pwrite              = 1'b0;
      paddr               = '0;
      pwdata              = '0;
      req_if.valid        = 1'b0;
      req_if.func         = FUNC_LOAD;
      req_if.vertex_index = '0;
      req_if.vertex_x     = '0;
      req_if.vertex_y     = '0;
      req_if.cell_column  = '0;
      req_if.cell_row     = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_nested_rings();
      test_coordinate_extremes();
      test_vertex_count_limits();
      test_random_polygons();
      wait_idle();
      if (mismatch_count == 0 && expected_cells.size() == 0) begin
         $display("[grid_point_in_polygon_test] OK");
      end else begin
         $display("[grid_point_in_polygon_test] ERROR");
      end
      $finish;
   end

endmodule
